// ===== rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants of the matrix-vector multiply core
// Widths of the stream fields, command codes, register indexes and the tag
// that travels with each request through the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int MVM_MAX_COLUMNS = 1024;

    localparam int ELEM_W    = 16;  // Q8.8 element or weight
    localparam int PROD_W    = 32;  // Q16.16 product
    localparam int ACC_W     = 48;  // Q32.16 accumulator
    localparam int COL_W     = 11;  // column_count and column positions
    localparam int ROW_W     = 16;  // row_count and row positions
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 16;  // element_value
    localparam int M_TDATA_W = 64;  // row_index, row_sum

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd1;

    localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = 11'd1024;
    localparam logic [ROW_W-1:0] ROW_COUNT_RESET    = 16'd1;

    typedef struct packed {
        logic             weight;  // request is a weight (else a vector load)
        logic             eor;     // weight closes its row
        logic [ROW_W-1:0] row;     // row index of the weight
        logic             last;    // row is the final row of the product
    } mvm_tag_t;

endpackage

// ===== rtl/mvm_mac.sv =====
// ----------------------------------------------------------------------------
// mvm_mac: multiply, saturating accumulate and result register
// Takes a weight and its vector element, registers the product, then adds it
// into the 48-bit accumulator and presents finished rows on the result port.
// ----------------------------------------------------------------------------
module mvm_mac
    import mvm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ELEM_W-1:0] in_value,
    input  logic signed [ELEM_W-1:0] in_elem,
    input  mvm_tag_t                 in_tag,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_W-1:0]     m_tdata,   // [15:0] row_index, [63:16] row_sum
    output logic                     m_tlast    // last_row
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                     p_valid_reg, p_valid_next;
    logic signed [PROD_W-1:0] p_prod_reg;
    mvm_tag_t                 p_tag_reg;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]         m_row_reg;
    logic signed [ACC_W-1:0]  m_sum_reg;
    logic                     m_last_reg;

    logic                     out_free;
    logic                     p_go;
    logic                     p_en;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  sum_sat;

    assign out_free = !m_valid_reg || m_tready;
    // A row-closing product waits until the result register is free.
    assign p_go     = p_valid_reg && (!p_tag_reg.eor || out_free);
    assign p_en     = !p_valid_reg || p_go;
    assign in_ready = p_en;

    always_comb begin
        sum_wide = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(p_prod_reg);
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        if (p_en) begin
            p_valid_next = in_valid;
        end
        acc_next = acc_reg;
        if (p_go) begin
            if (!p_tag_reg.weight || p_tag_reg.eor) begin
                acc_next = '0;
            end else begin
                acc_next = sum_sat;
            end
        end
        m_valid_next = m_valid_reg;
        if (p_go && p_tag_reg.eor) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_en && in_valid) begin
            p_prod_reg <= PROD_W'(in_value) * PROD_W'(in_elem);
            p_tag_reg  <= in_tag;
        end
        if (p_go && p_tag_reg.eor) begin
            m_row_reg  <= p_tag_reg.row;
            m_sum_reg  <= sum_sat;
            m_last_reg <= p_tag_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_sum_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_row_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        p_go && p_tag_reg.eor |=> m_valid_reg)
        else $error("finished row did not reach the result register");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> $stable(m_sum_reg) && $stable(m_row_reg))
        else $error("pending result overwritten");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        p_go && (p_tag_reg.eor || !p_tag_reg.weight) |=> acc_reg == '0)
        else $error("accumulator not cleared after row end or vector load");
`endif

endmodule

// ===== rtl/matrix_vector_multiply_core.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core: fixed-point matrix-vector product
// Stores a Q8.8 vector, then multiplies streamed row-major weights by it and
// emits one saturated Q32.16 row sum per matrix row.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tuser[0] cmd, tdata[15:0] element_value
//  m_*      | out       | tdata[15:0] row_index, tdata[63:16] row_sum, tlast last_row
//  cfg_*    | in        | cfg_index register, cfg_data value (always ready)
//
// One request per cycle is taken while s_tready stays high; a row-closing
// weight passes the read stage (store read), the product register (multiply)
// and the result register (accumulate) before its row sum shows on m_tvalid.
// The vector store has one port and is written or read once per request.
// Reset is synchronous on aresetn; the vector store is not cleared.
// With m_tready low and a row sum waiting, requests keep flowing until the next
// row-closing weight reaches the multiply stage; one more request is then taken
// into the read stage before s_tready drops.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core
    import mvm_pkg::*;
#(
    parameter int MAX_COLUMNS = MVM_MAX_COLUMNS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] element_value
    input  logic [0:0]            s_tuser,   // [0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] row_index, [63:16] row_sum
    output logic                  m_tlast,   // last_row
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [16:0] MAX_COLS_W = 17'(MAX_COLUMNS);

    logic [COL_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [COL_W-1:0]  load_pos_reg, load_pos_next;
    logic [COL_W-1:0]  col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;

    logic [COL_W-1:0]  cols;
    logic [ROW_W-1:0]  rows;
    logic [COL_W-1:0]  lp, cp;
    logic [COL_W:0]    lp_inc, cp_inc;
    logic [ROW_W-1:0]  rp;
    logic [ROW_W:0]    rp_inc;
    logic              row_end;
    logic              row_last;

    logic              accept;
    logic              load_en;
    logic              read_en;

    logic signed [ELEM_W-1:0] store_mem [MAX_COLUMNS];
    logic signed [ELEM_W-1:0] rd_data_reg;

    logic              r_valid_reg, r_valid_next;
    logic signed [ELEM_W-1:0] r_value_reg;
    mvm_tag_t          r_tag_reg, tag_in;
    logic              mac_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= COLUMN_COUNT_RESET;
            row_count_reg <= ROW_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COLUMN_COUNT: col_count_reg <= cfg_data[COL_W-1:0];
                REG_ROW_COUNT:    row_count_reg <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range counts are clamped to the legal span.
    always_comb begin
        if (col_count_reg == '0) begin
            cols = COL_W'(1);
        end else if ({6'd0, col_count_reg} > MAX_COLS_W) begin
            cols = MAX_COLS_W[COL_W-1:0];
        end else begin
            cols = col_count_reg;
        end
        rows = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
    end

    assign accept  = s_tvalid && s_tready;
    assign load_en = accept && (s_tuser[0] == CMD_LOAD);
    assign read_en = accept && (s_tuser[0] == CMD_WEIGHT);

    // Positions left beyond their bound by a register change restart at zero.
    always_comb begin
        lp       = (load_pos_reg >= cols) ? '0 : load_pos_reg;
        cp       = (col_pos_reg >= cols) ? '0 : col_pos_reg;
        rp       = (row_pos_reg >= rows) ? '0 : row_pos_reg;
        lp_inc   = {1'b0, lp} + 1'b1;
        cp_inc   = {1'b0, cp} + 1'b1;
        rp_inc   = {1'b0, rp} + 1'b1;
        row_end  = cp_inc >= {1'b0, cols};
        row_last = rp_inc >= {1'b0, rows};

        load_pos_next = load_pos_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        if (load_en) begin
            load_pos_next = (lp_inc >= {1'b0, cols}) ? '0 : lp_inc[COL_W-1:0];
            col_pos_next  = '0;
            row_pos_next  = '0;
        end else if (read_en) begin
            col_pos_next = row_end ? '0 : cp_inc[COL_W-1:0];
            if (row_end) begin
                row_pos_next = row_last ? '0 : rp_inc[ROW_W-1:0];
            end else begin
                row_pos_next = rp;
            end
        end

        tag_in.weight = (s_tuser[0] == CMD_WEIGHT);
        tag_in.eor    = (s_tuser[0] == CMD_WEIGHT) && row_end;
        tag_in.row    = rp;
        tag_in.last   = row_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
        end else begin
            load_pos_reg <= load_pos_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            store_mem[AW'(lp)] <= s_tdata;
        end
        if (read_en) begin
            rd_data_reg <= store_mem[AW'(cp)];
        end
    end

    // Read stage: holds the request while the store data is fetched.
    assign s_tready = !r_valid_reg || mac_ready;

    always_comb begin
        r_valid_next = r_valid_reg;
        if (s_tready) begin
            r_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else begin
            r_valid_reg <= r_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            r_value_reg <= s_tdata;
            r_tag_reg   <= tag_in;
        end
    end

    mvm_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (r_valid_reg),
        .in_ready (mac_ready),
        .in_value (r_value_reg),
        .in_elem  (rd_data_reg),
        .in_tag   (r_tag_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |=> col_pos_reg == '0 && row_pos_reg == '0)
        else $error("vector load did not restart row and column positions");

    a_row_end_tagged: assert property (@(posedge aclk) disable iff (!aresetn)
        read_en && row_end |=> r_valid_reg && r_tag_reg.eor)
        else $error("row-closing weight lost its end-of-row mark");

    a_col_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        read_en && row_end |=> col_pos_reg == '0)
        else $error("column position did not wrap at row end");
`endif

endmodule
